// ----- rtl/sqvg_pkg.sv -----
// Shared types, constants and sine table function for the sprite quad vertex generator.
`timescale 1ns / 1ps
package sqvg_pkg;
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;
    localparam logic [1:0] REG_SCALE_X = 2'd0;
    localparam logic [1:0] REG_SCALE_Y = 2'd1;
    localparam logic [15:0] SCALE_RESET = 16'd4096;
    localparam int OUT_W = 20;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] width;
        logic signed [15:0] height;
        logic [15:0] tex_left;
        logic [15:0] tex_top;
        logic [15:0] tex_right;
        logic [15:0] tex_bottom;
        logic [31:0] tint;
    } t_sprite;

    // Asr with floor on a 64-bit value, for elaboration-time table math.
    function automatic longint asr64(longint v, int n);
        return v >>> n;
    endfunction

    // sin(pi/2*t), t in Q30, result Q14 in 0..16384.
    function automatic longint quarter_sine(longint t);
        longint t2;
        longint acc;
        t2 = (t * t) >>> 30;
        acc = 172272;
        acc = -5026925 + asr64(acc * t2, 30);
        acc = 85569144 + asr64(acc * t2, 30);
        acc = -693598342 + asr64(acc * t2, 30);
        acc = 1686629713 + asr64(acc * t2, 30);
        acc = asr64(acc * t, 30);
        acc = asr64(acc + 32768, 16);
        if (acc < 0) acc = 0;
        if (acc > 16384) acc = 16384;
        return acc;
    endfunction

    // Sine of a Q0.32 phase, Q1.14 in 18 bits.
    function automatic logic signed [17:0] sine_of_phase(logic [31:0] phase);
        longint x;
        longint v;
        x = longint'(phase[29:0]);
        if (phase[30]) v = quarter_sine((longint'(1) << 30) - x);
        else v = quarter_sine(x);
        if (phase[31]) v = -v;
        return 18'(v);
    endfunction
endpackage

// ----- rtl/sqvg_trig_rom.sv -----
// Sine and cosine lookup table with registered outputs.
`timescale 1ns / 1ps
module sqvg_trig_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] i_idx,
    output logic signed [17:0]          o_sin,
    output logic signed [17:0]          o_cos
);
    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    logic signed [17:0] r_rom [SINE_TABLE_DEPTH];
    logic [IW-1:0] cos_idx;

    // Entry i sits at phase i/DEPTH of a turn; depth is a power of two.
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
        assign r_rom[g] = sqvg_pkg::sine_of_phase(32'((64'(g) << 32) >> IW));
    end

    assign cos_idx = i_idx + IW'(SINE_TABLE_DEPTH / 4);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= r_rom[i_idx];
            o_cos <= r_rom[cos_idx];
        end
    end
endmodule

// ----- rtl/sprite_quad_vertex_generator.sv -----
// Top level: sprite in, four rotated quad vertices out.
//
//  channel   handshake            payload
//  sprite    i_valid / o_stall    i_center_x .. i_tint
//  vertex    o_valid / i_stall    o_vert_x .. o_last_vertex
//  config    APB psel/penable     paddr, pwdata, prdata
//
// The output emits one vertex a cycle while i_stall is low, so in steady state a sprite is
// taken once per four vertices. An accepted sprite passes through the scale and table read,
// rotate, sum and round stages and is then loaded into the sequencer, which presents its first vertex.
// Synchronous active-low reset clears all valid bits and sets both scales to 1.0.
// A stalled vertex holds the sequencer; the pipe advances while its last stage can move on.
`timescale 1ns / 1ps
module sprite_quad_vertex_generator #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_center_x,
    input  logic signed [15:0] i_center_y,
    input  logic signed [15:0] i_width,
    input  logic signed [15:0] i_height,
    input  logic [15:0]        i_spin_angle,
    input  logic [15:0]        i_tex_left,
    input  logic [15:0]        i_tex_top,
    input  logic [15:0]        i_tex_right,
    input  logic [15:0]        i_tex_bottom,
    input  logic [31:0]        i_tint,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [19:0] o_vert_x,
    output logic signed [19:0] o_vert_y,
    output logic [15:0]        o_tex_u,
    output logic [15:0]        o_tex_v,
    output logic [31:0]        o_vert_color,
    output logic [1:0]         o_corner,
    output logic               o_last_vertex
);
    localparam int IW = $clog2(SINE_TABLE_DEPTH);

    logic [15:0] r_scale_x, r_scale_y;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= sqvg_pkg::SCALE_RESET;
            r_scale_y <= sqvg_pkg::SCALE_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == sqvg_pkg::REG_SCALE_X[0]) r_scale_x <= pwdata[15:0];
            else r_scale_y <= pwdata[15:0];
        end
    end
    always_comb begin
        unique case (paddr[2])
            sqvg_pkg::REG_SCALE_X[0]: prdata = {16'd0, r_scale_x};
            default:                  prdata = {16'd0, r_scale_y};
        endcase
    end

    // Pipe advances when stage 4 is empty or the vertex sequencer can take its sprite.
    logic adv;
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_busy;
    logic [1:0] r_cnt;
    logic seq_load;
    assign seq_load = r_v4 && (!r_busy || (!i_stall && r_cnt == sqvg_pkg::CORNER_BL));
    assign adv = !r_v4 || seq_load;
    assign o_stall = !adv;
    logic acc;
    assign acc = i_valid && !o_stall;

    // Stage 1: table read and scale multiplies.
    sqvg_pkg::t_sprite r_s1, r_s2, r_s3, r_s4;
    logic signed [17:0] sn, cs;
    logic signed [33:0] r_cx1, r_cy1, r_hx1, r_hy1;
    sqvg_trig_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
        .i_clk(i_clk), .i_en(adv), .i_idx(i_spin_angle[15 -: IW]),
        .o_sin(sn), .o_cos(cs)
    );
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (adv) r_v1 <= acc;
        if (adv) begin
            r_s1 <= '{i_center_x, i_center_y, i_width, i_height, i_tex_left,
                      i_tex_top, i_tex_right, i_tex_bottom, i_tint};
            r_cx1 <= 34'(i_center_x * $signed({1'b0, r_scale_x})) <<< 1;
            r_cy1 <= 34'(i_center_y * $signed({1'b0, r_scale_y})) <<< 1;
            r_hx1 <= 34'(i_width * $signed({1'b0, r_scale_x}));
            r_hy1 <= 34'(i_height * $signed({1'b0, r_scale_y}));
        end
    end

    // Stage 2: rotation products.
    logic signed [51:0] r_hxc, r_hxs, r_hyc, r_hys;
    logic signed [47:0] r_cx2, r_cy2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (adv) r_v2 <= r_v1;
        if (adv) begin
            r_s2 <= r_s1;
            r_hxc <= 52'(r_hx1 * cs);
            r_hxs <= 52'(r_hx1 * sn);
            r_hyc <= 52'(r_hy1 * cs);
            r_hys <= 52'(r_hy1 * sn);
            r_cx2 <= 48'(r_cx1) <<< 14;
            r_cy2 <= 48'(r_cy1) <<< 14;
        end
    end

    // Stage 3: four corner sums per axis. a=hx*c-hy*s, b=hx*s+hy*c.
    logic signed [53:0] r_px [4];
    logic signed [53:0] r_py [4];
    logic signed [53:0] a, b;
    assign a = 54'(r_hxc) - 54'(r_hys);
    assign b = 54'(r_hxs) + 54'(r_hyc);
    logic signed [53:0] a2, b2;
    assign a2 = 54'(r_hxc) + 54'(r_hys);
    assign b2 = 54'(r_hxs) - 54'(r_hyc);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (adv) r_v3 <= r_v2;
        if (adv) begin
            r_s3 <= r_s2;
            // TL(-,-) TR(+,-) BR(+,+) BL(-,+)
            r_px[0] <= 54'(r_cx2) - a;  r_py[0] <= 54'(r_cy2) - b;
            r_px[1] <= 54'(r_cx2) + a2; r_py[1] <= 54'(r_cy2) + b2;
            r_px[2] <= 54'(r_cx2) + a;  r_py[2] <= 54'(r_cy2) + b;
            r_px[3] <= 54'(r_cx2) - a2; r_py[3] <= 54'(r_cy2) - b2;
        end
    end

    // Stage 4: round and saturate.
    function automatic logic signed [19:0] sat_out(logic signed [53:0] v);
        logic signed [53:0] r;
        logic signed [26:0] q;
        r = v + 54'sd67108864;
        q = 27'(r >>> 27);
        if (q > 27'sd524287) return 20'sd524287;
        if (q < -27'sd524288) return -20'sd524288;
        return q[19:0];
    endfunction
    logic signed [19:0] r_ox [4];
    logic signed [19:0] r_oy [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (adv) r_v4 <= r_v3;
        if (adv) begin
            r_s4 <= r_s3;
            for (int k = 0; k < 4; k++) begin
                r_ox[k] <= sat_out(r_px[k]);
                r_oy[k] <= sat_out(r_py[k]);
            end
        end
    end

    // Stage 5: vertex sequencer, holds the sprite and walks the corners.
    sqvg_pkg::t_sprite r_sq;
    logic signed [19:0] r_qx [4];
    logic signed [19:0] r_qy [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= sqvg_pkg::CORNER_TL;
        end else if (seq_load) begin
            r_busy <= 1'b1;
            r_cnt  <= sqvg_pkg::CORNER_TL;
        end else if (r_busy && !i_stall) begin
            if (r_cnt == sqvg_pkg::CORNER_BL) r_busy <= 1'b0;
            r_cnt <= r_cnt + 2'd1;
        end
        if (seq_load) begin
            r_sq <= r_s4;
            r_qx <= r_ox;
            r_qy <= r_oy;
        end
    end

    assign o_valid       = r_busy;
    assign o_vert_x      = r_qx[r_cnt];
    assign o_vert_y      = r_qy[r_cnt];
    assign o_tex_u       = (r_cnt == sqvg_pkg::CORNER_TL || r_cnt == sqvg_pkg::CORNER_BL)
                           ? r_sq.tex_left : r_sq.tex_right;
    assign o_tex_v       = (r_cnt == sqvg_pkg::CORNER_TL || r_cnt == sqvg_pkg::CORNER_TR)
                           ? r_sq.tex_top : r_sq.tex_bottom;
    assign o_vert_color  = r_sq.tint;
    assign o_corner      = r_cnt;
    assign o_last_vertex = (r_cnt == sqvg_pkg::CORNER_BL);
endmodule

// ----- rtl/sqvg_checker.sv -----
// Port-level checker for the sprite quad vertex generator, bound to the top.
`timescale 1ns / 1ps
module sqvg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_corner,
    input logic        o_last_vertex,
    input logic        pready
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_vertex == (o_corner == sqvg_pkg::CORNER_BL)))
        else $error("last flag mismatch");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_corner != sqvg_pkg::CORNER_BL) |=>
        (o_valid && o_corner == $past(o_corner) + 2'd1))
        else $error("corner sequence broken");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_corner)))
        else $error("stalled vertex changed");
    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind sprite_quad_vertex_generator sqvg_checker u_sqvg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_corner(o_corner), .o_last_vertex(o_last_vertex), .pready(pready)
);

// ----- verif/sprite_quad_vertex_generator_tb.sv -----
// Testbench for the sprite quad vertex generator: directed and random sprites, scale settings.
`timescale 1ns / 1ps
module sprite_quad_vertex_generator_tb;

    typedef struct {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [15:0]        u;
        logic [15:0]        v;
        logic [31:0]        color;
        logic [1:0]         corner;
        logic               last;
    } t_vertex;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_center_x, i_center_y, i_width, i_height;
    logic [15:0]        i_spin_angle, i_tex_left, i_tex_top, i_tex_right, i_tex_bottom;
    logic [31:0]        i_tint;
    logic               o_valid;
    logic               i_stall;
    logic signed [19:0] o_vert_x, o_vert_y;
    logic [15:0]        o_tex_u, o_tex_v;
    logic [31:0]        o_vert_color;
    logic [1:0]         o_corner;
    logic               o_last_vertex;

    t_vertex     vertex_q[$];
    logic [15:0] scale_x_model, scale_y_model;
    int          error_count;
    int          send_idle_pct, stall_pct;
    int          quiet_cycles;
    bit          sprite_taken;

    sprite_quad_vertex_generator uut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Quarter-wave sine, t in Q30, result Q14.
    function automatic longint quarter_wave(longint t);
        longint t2, acc;
        t2 = (t * t) >>> 30;
        acc = 172272;
        acc = -5026925 + ((acc * t2) >>> 30);
        acc = 85569144 + ((acc * t2) >>> 30);
        acc = -693598342 + ((acc * t2) >>> 30);
        acc = 1686629713 + ((acc * t2) >>> 30);
        acc = (acc * t) >>> 30;
        acc = (acc + 32768) >>> 16;
        if (acc < 0) acc = 0;
        if (acc > 16384) acc = 16384;
        return acc;
    endfunction

    function automatic longint table_sine(logic [31:0] phase);
        longint mag;
        if (phase[30]) mag = quarter_wave((longint'(1) << 30) - longint'(phase[29:0]));
        else mag = quarter_wave(longint'(phase[29:0]));
        return phase[31] ? -mag : mag;
    endfunction

    function automatic logic signed [19:0] round_sat(longint q31);
        longint r;
        r = (q31 + (longint'(1) << 26)) >>> 27;
        if (r < -524288) r = -524288;
        if (r > 524287) r = 524287;
        return 20'(r);
    endfunction

    // Expand one sprite into its four expected vertices.
    function automatic void expand_sprite(sqvg_pkg::t_sprite s, logic [15:0] angle);
        longint cx, cy, hx, hy, sn, cs, ox, oy;
        logic [31:0] phase;
        t_vertex vtx;
        cx = longint'(s.center_x) * longint'(scale_x_model) * 2;
        cy = longint'(s.center_y) * longint'(scale_y_model) * 2;
        hx = longint'(s.width) * longint'(scale_x_model);
        hy = longint'(s.height) * longint'(scale_y_model);
        phase = {angle[15:6], 22'd0};
        sn = table_sine(phase);
        cs = table_sine(phase + 32'h4000_0000);
        for (int k = 0; k < 4; k++) begin
            ox = (k == 0 || k == 3) ? -hx : hx;
            oy = (k < 2) ? -hy : hy;
            vtx.x = round_sat(ox * cs - oy * sn + cx * 16384);
            vtx.y = round_sat(ox * sn + oy * cs + cy * 16384);
            vtx.u = (k == 0 || k == 3) ? s.tex_left : s.tex_right;
            vtx.v = (k < 2) ? s.tex_top : s.tex_bottom;
            vtx.color = s.tint;
            vtx.corner = 2'(k);
            vtx.last = (k == 3);
            vertex_q = {vertex_q, vtx};
        end
    endfunction

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_vertex exp_v;
        if (i_rst_n && o_valid && !i_stall) begin
            if (vertex_q.size() == 0) begin
                $display("%0t: unexpected vertex x=%0d y=%0d corner=%0d", $time,
                         o_vert_x, o_vert_y, o_corner);
                error_count++;
            end else begin
                exp_v = vertex_q.pop_front();
                if (o_vert_x !== exp_v.x || o_vert_y !== exp_v.y || o_tex_u !== exp_v.u ||
                    o_tex_v !== exp_v.v || o_vert_color !== exp_v.color ||
                    o_corner !== exp_v.corner || o_last_vertex !== exp_v.last) begin
                    $display("%0t: expected x=%0d y=%0d u=%h v=%h c=%h k=%0d l=%b", $time,
                             exp_v.x, exp_v.y, exp_v.u, exp_v.v, exp_v.color,
                             exp_v.corner, exp_v.last);
                    $display("%0t: actual   x=%0d y=%0d u=%h v=%h c=%h k=%0d l=%b", $time,
                             o_vert_x, o_vert_y, o_tex_u, o_tex_v, o_vert_color,
                             o_corner, o_last_vertex);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles where neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000) begin
            $display("sprite_quad_vertex_generator_tb: errors");
            $finish;
        end
    end

    task automatic send_sprite(sqvg_pkg::t_sprite s, logic [15:0] angle);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        {i_center_x, i_center_y, i_width, i_height} = {s.center_x, s.center_y, s.width, s.height};
        {i_tex_left, i_tex_top, i_tex_right, i_tex_bottom} =
            {s.tex_left, s.tex_top, s.tex_right, s.tex_bottom};
        i_tint = s.tint;
        i_spin_angle = angle;
        sprite_taken = 0;
        while (!sprite_taken) begin
            @(posedge i_clk);
            if (!o_stall) begin
                sprite_taken = 1;
                expand_sprite(s, angle);
            end
            @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (vertex_q.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_scale(logic [1:0] reg_id, logic [15:0] value);
        paddr <= {reg_id[0], 2'b00};
        pwdata <= {16'd0, value};
        psel <= 1'b1;
        pwrite <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_id == sqvg_pkg::REG_SCALE_X) scale_x_model = value;
        else scale_y_model = value;
        @(negedge i_clk);
        paddr <= {reg_id[0], 2'b00};
        psel <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata[15:0] !== value) begin
            $display("%0t: readback expected %h actual %h", $time, value, prdata[15:0]);
            error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic sqvg_pkg::t_sprite random_sprite();
        sqvg_pkg::t_sprite s;
        s = sqvg_pkg::t_sprite'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 16'($urandom)});
        // keep most sprites on screen-sized values so saturation stays occasional
        if ($urandom_range(3) != 0) begin
            s.center_x = 16'($signed($urandom_range(8000)) - 4000);
            s.center_y = 16'($signed($urandom_range(8000)) - 4000);
            s.width = 16'($signed($urandom_range(4000)) - 1000);
            s.height = 16'($signed($urandom_range(4000)) - 1000);
        end
        return s;
    endfunction

    task automatic test_directed();
        sqvg_pkg::t_sprite s;
        logic [15:0] angles[10] = '{16'd0, 16'd63, 16'd64, 16'd16384, 16'd32768,
                                    16'd49152, 16'd65535, 16'd8192, 16'd24576, 16'd40000};
        send_idle_pct = 0;
        stall_pct = 0;
        s = '{16'sd160, -16'sd320, 16'sd64, 16'sd32, 16'd0, 16'd0, 16'd32768, 16'd32768,
              32'hFF80_4020};
        foreach (angles[i]) send_sprite(s, angles[i]);
        s = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 32'hFFFF_FFFF};
        send_sprite(s, 16'd0);
        send_sprite(s, 16'd65535);
        s = '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 16'd0, 16'd0, 16'd0, 16'd0,
              32'd0};
        send_sprite(s, 16'd0);
        send_sprite(s, 16'd32768);
        // negative size mirrors the quad
        s = '{16'sd0, 16'sd0, -16'sd100, -16'sd50, 16'd100, 16'd200, 16'd40000, 16'd300,
              32'h1234_5678};
        send_sprite(s, 16'd5000);
        s.width = 16'sd0;
        s.height = 16'sd0;
        send_sprite(s, 16'd12345);
        drain();
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            send_sprite(random_sprite(), 16'($urandom));
            // sender waits for every vertex once, halfway through
            if (n == count / 2) drain();
        end
        drain();
    endtask

    task automatic test_scales();
        write_scale(sqvg_pkg::REG_SCALE_X, 16'd0);
        write_scale(sqvg_pkg::REG_SCALE_Y, 16'hFFFF);
        test_random(30, 32, 32);
        write_scale(sqvg_pkg::REG_SCALE_X, 16'hFFFF);
        write_scale(sqvg_pkg::REG_SCALE_Y, 16'd0);
        test_random(30, 0, 67);
        write_scale(sqvg_pkg::REG_SCALE_X, 16'($urandom));
        write_scale(sqvg_pkg::REG_SCALE_Y, 16'($urandom));
        test_random(30, 67, 0);
        write_scale(sqvg_pkg::REG_SCALE_X, 16'd2048);
        write_scale(sqvg_pkg::REG_SCALE_Y, 16'd8192);
        test_random(30, 0, 0);
        write_scale(sqvg_pkg::REG_SCALE_X, sqvg_pkg::SCALE_RESET);
        write_scale(sqvg_pkg::REG_SCALE_Y, sqvg_pkg::SCALE_RESET);
    endtask

    initial begin
        error_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        scale_x_model = sqvg_pkg::SCALE_RESET;
        scale_y_model = sqvg_pkg::SCALE_RESET;
        i_rst_n = 1'b0;
        {psel, penable, pwrite, paddr, pwdata} = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        {i_center_x, i_center_y, i_width, i_height, i_spin_angle} = '0;
        {i_tex_left, i_tex_top, i_tex_right, i_tex_bottom, i_tint} = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(90, 0, 0);
        test_random(80, 67, 0);
        test_random(80, 0, 67);
        test_random(80, 32, 32);
        test_scales();
        if (error_count == 0) $display("sprite_quad_vertex_generator_tb: clean");
        else $display("sprite_quad_vertex_generator_tb: errors");
        $finish;
    end
endmodule
